// File: sv/rwc_pkg.sv
// Shared types and constants of the replay window checker.
package rwc_pkg;

  // Fixed field widths
  localparam int CTR_W     = 64;
  localparam int CNT_W     = $clog2(CTR_W);
  localparam int WORD_W    = 32;
  localparam int VERDICT_W = 3;

  // Reset value of the reject limit register
  localparam logic [CTR_W-1:0] REJECT_LIMIT_RST = 64'hFFFF_FFFF_FFFF_DFFF;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_ACCEPTED   = 3'd0,
    VERDICT_OVER_LIMIT = 3'd1,
    VERDICT_TOO_OLD    = 3'd2,
    VERDICT_REPLAY     = 3'd3,
    VERDICT_RESTARTED  = 3'd4
  } verdict_t;

  typedef enum logic [3:0] {
    ST_INIT_WIPE,
    ST_IDLE,
    ST_EVAL,
    ST_CLASS,
    ST_INDEX,
    ST_CHK_RD,
    ST_CHK_TEST,
    ST_SEG_RD,
    ST_SEG_WR,
    ST_MOD,
    ST_SWEEP,
    ST_WIPE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic     load;
    logic     restart;
    logic     eval;
    logic     classify;
    logic     index;
    logic     chk_rd;
    logic     chk_wr;
    logic     seg_rd;
    logic     seg_wr;
    logic     mod_step;
    logic     sweep;
    logic     sweep_set;
    logic     commit_hs;
    logic     report;
    verdict_t verdict;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic over;
    logic gt;
    logic far;
    logic bit_set;
    logic seg_last;
    logic mod_last;
    logic sweep_last;
  } dp_sts_t;

endpackage

// File: sv/rwc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rwc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/rwc_ctrl.sv
// Sequencing state machine of the replay window checker.
module rwc_ctrl import rwc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  logic    in_operation,
  input  dp_sts_t sts,
  output dp_cmd_t cmd,
  output logic    busy
);

  state_t state_r, state_nxt;

  // State register; reset starts the bitmap clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT_WIPE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.verdict = VERDICT_ACCEPTED;
    case (state_r)
      ST_INIT_WIPE: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (in_operation) begin
            cmd.restart = 1'b1;
            state_nxt   = ST_WIPE;
          end else begin
            state_nxt = ST_EVAL;
          end
        end
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = ST_CLASS;
      end
      ST_CLASS: begin
        if (sts.over) begin
          cmd.report  = 1'b1;
          cmd.verdict = VERDICT_OVER_LIMIT;
          state_nxt   = ST_IDLE;
        end else begin
          cmd.classify = 1'b1;
          state_nxt    = ST_INDEX;
        end
      end
      ST_INDEX: begin
        if (!sts.gt && sts.far) begin
          cmd.report  = 1'b1;
          cmd.verdict = VERDICT_TOO_OLD;
          state_nxt   = ST_IDLE;
        end else begin
          cmd.index = 1'b1;
          if (sts.gt && sts.far) begin
            state_nxt = ST_MOD;
          end else if (sts.gt) begin
            state_nxt = ST_SEG_RD;
          end else begin
            state_nxt = ST_CHK_RD;
          end
        end
      end
      ST_CHK_RD: begin
        cmd.chk_rd = 1'b1;
        state_nxt  = ST_CHK_TEST;
      end
      ST_CHK_TEST: begin
        cmd.report = 1'b1;
        if (sts.bit_set) begin
          cmd.verdict = VERDICT_REPLAY;
        end else begin
          cmd.chk_wr  = 1'b1;
          cmd.verdict = VERDICT_ACCEPTED;
        end
        state_nxt = ST_IDLE;
      end
      ST_SEG_RD: begin
        cmd.seg_rd = 1'b1;
        state_nxt  = ST_SEG_WR;
      end
      ST_SEG_WR: begin
        cmd.seg_wr = 1'b1;
        if (sts.seg_last) begin
          cmd.commit_hs = 1'b1;
          cmd.report    = 1'b1;
          cmd.verdict   = VERDICT_ACCEPTED;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_SEG_RD;
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) begin
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        cmd.sweep     = 1'b1;
        cmd.sweep_set = 1'b1;
        if (sts.sweep_last) begin
          cmd.commit_hs = 1'b1;
          cmd.report    = 1'b1;
          cmd.verdict   = VERDICT_ACCEPTED;
          state_nxt     = ST_IDLE;
        end
      end
      ST_WIPE: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          cmd.report  = 1'b1;
          cmd.verdict = VERDICT_RESTARTED;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// File: sv/rwc_dp.sv
// Datapath of the replay window checker: counters, index math and bitmap RAM.
module rwc_dp import rwc_pkg::*; #(
  parameter int WINDOW = 2048
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_sts_t              sts,
  input  logic [CTR_W-1:0]     in_packet_counter,
  input  logic                 cfg_we,
  input  logic [CTR_W-1:0]     cfg_data,
  output logic                 out_valid,
  output logic [VERDICT_W-1:0] out_verdict
);

  localparam int WORDS = (WINDOW + WORD_W - 1) / WORD_W;
  localparam int IW    = $clog2(WINDOW);
  localparam int AW    = $clog2(WORDS);
  localparam logic [IW:0]    WIN       = (IW+1)'(WINDOW);
  localparam logic [AW-1:0]  LAST_WORD = AW'(WORDS - 1);
  // Remainder by the window size, 16 counter bits per two-step round
  localparam int CHUNK_W = 16;
  localparam int RED_W   = IW + CHUNK_W;
  localparam int RCP_W   = CHUNK_W + 1;
  localparam int PRD_W   = RED_W + RCP_W;
  localparam logic [RCP_W-1:0] RECIP     = RCP_W'((64'd1 << RED_W) / WINDOW);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(2 * CTR_W / CHUNK_W - 1);

  // Session state and configuration
  logic [CTR_W-1:0] limit_r;
  logic [CTR_W-1:0] hs_r;
  logic [IW-1:0]    hsidx_r;

  // Per-item working registers
  logic [CTR_W-1:0] ctr_r;
  logic             over_r;
  logic             borrow_r;
  logic [CTR_W-1:0] diff_r;
  logic             gt_r;
  logic             far_r;
  logic [CTR_W-1:0] mag_r;
  logic [IW-1:0]    tgt_r;
  logic [IW-1:0]    pos_r;
  logic [IW-1:0]    rem_r;
  logic [IW-1:0]    mod_r;
  logic [RCP_W-1:0] quo_r;
  logic [CNT_W-1:0] mod_cnt_r;
  logic [AW-1:0]    swp_cnt_r;
  logic             out_valid_r;
  verdict_t         out_verdict_r;

  // Combinational values
  logic [CTR_W:0]     sub_full;
  logic [CTR_W-1:0]   mag_nxt;
  logic [IW:0]        sum_up, up_idx, sum_dn, dn_idx, pos_inc, pos_init;
  logic [IW-1:0]      tgt_nxt;
  logic [4:0]         seg_lo;
  logic [5:0]         space_word;
  logic [IW:0]        space_end, space;
  logic               seg_last;
  logic [5:0]         seg_n;
  logic [WORD_W:0]    seg_ones;
  logic [2*WORD_W-1:0] seg_wide;
  logic [WORD_W-1:0]  seg_mask;
  logic [IW:0]        pos_adv, pos_wrap;
  logic [1:0]         chunk_sel;
  logic [CHUNK_W-1:0] chunk;
  logic [RED_W-1:0]   red_x, red_qw, red_rem;
  logic [PRD_W-1:0]   red_prd;
  logic [RCP_W-1:0]   quo_nxt;
  logic [IW-1:0]      mod_nxt;
  logic [WORD_W-1:0]  tgt_mask;
  logic [AW-1:0]      tgt_word, pos_word;

  // RAM port signals
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  // Distance between counter and highest seen
  assign sub_full = {1'b0, ctr_r} - {1'b0, hs_r};
  assign mag_nxt  = borrow_r ? (~diff_r + CTR_W'(1)) : diff_r;

  // Bit index of the counter from the index of the highest seen
  always_comb begin
    sum_up  = {1'b0, hsidx_r} + {1'b0, mag_r[IW-1:0]};
    up_idx  = (sum_up >= WIN) ? (sum_up - WIN) : sum_up;
    sum_dn  = {1'b0, hsidx_r} + WIN - {1'b0, mag_r[IW-1:0]};
    dn_idx  = (sum_dn >= WIN) ? (sum_dn - WIN) : sum_dn;
    tgt_nxt = gt_r ? up_idx[IW-1:0] : dn_idx[IW-1:0];
    pos_inc  = {1'b0, hsidx_r} + (IW+1)'(1);
    pos_init = (pos_inc == WIN) ? '0 : pos_inc;
  end

  // Clear segment: bits of the current word from pos up to the word end,
  // the window end or the bit of the new counter, whichever comes first
  always_comb begin
    seg_lo     = pos_r[4:0];
    space_word = 6'd32 - {1'b0, seg_lo};
    space_end  = WIN - {1'b0, pos_r};
    space      = ((IW+1)'(space_word) < space_end) ? (IW+1)'(space_word) : space_end;
    seg_last   = ({1'b0, rem_r} <= space);
    seg_n      = seg_last ? 6'({1'b0, rem_r}) : 6'(space);
    seg_ones   = ((WORD_W+1)'(1) << seg_n) - (WORD_W+1)'(1);
    seg_wide   = {{(WORD_W-1){1'b0}}, seg_ones} << seg_lo;
    seg_mask   = seg_wide[WORD_W-1:0];
    pos_adv    = {1'b0, pos_r} + (IW+1)'(seg_n);
    pos_wrap   = (pos_adv == WIN) ? '0 : pos_adv;
  end

  // One step of the chunked remainder by the window size, top chunk first:
  // an even step estimates the quotient by a reciprocal multiply, an odd
  // step subtracts the product and corrects the remainder once
  always_comb begin
    chunk_sel = ~mod_cnt_r[2:1];
    chunk     = ctr_r[{chunk_sel, 4'b0000} +: CHUNK_W];
    red_x     = {mod_r, chunk};
    red_prd   = PRD_W'(red_x) * PRD_W'(RECIP);
    quo_nxt   = red_prd[PRD_W-1:RED_W];
    red_qw    = RED_W'(quo_r) * RED_W'(WIN);
    red_rem   = red_x - red_qw;
    mod_nxt   = (red_rem >= RED_W'(WIN)) ? IW'(red_rem - RED_W'(WIN)) : IW'(red_rem);
  end

  assign tgt_mask = WORD_W'(1) << tgt_r[4:0];
  assign tgt_word = tgt_r[AW+4:5];
  assign pos_word = pos_r[AW+4:5];

  // Bitmap RAM access selection
  always_comb begin
    ram_re    = cmd.chk_rd | cmd.seg_rd;
    ram_raddr = cmd.seg_rd ? pos_word : tgt_word;
    ram_we    = cmd.sweep | cmd.chk_wr | cmd.seg_wr;
    ram_waddr = tgt_word;
    ram_wdata = ram_rdata | tgt_mask;
    if (cmd.sweep) begin
      ram_waddr = swp_cnt_r;
      ram_wdata = (cmd.sweep_set && (swp_cnt_r == tgt_word)) ? tgt_mask : '0;
    end else if (cmd.seg_wr) begin
      ram_waddr = pos_word;
      ram_wdata = (ram_rdata & ~seg_mask) | (seg_last ? tgt_mask : '0);
    end
  end

  // Session state, sequencing counters and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= REJECT_LIMIT_RST;
      hs_r        <= '0;
      hsidx_r     <= '0;
      swp_cnt_r   <= '0;
      mod_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.report;
      if (cfg_we) begin
        limit_r <= cfg_data;
      end
      if (cmd.restart) begin
        hs_r      <= '0;
        hsidx_r   <= '0;
        swp_cnt_r <= '0;
      end
      if (cmd.commit_hs) begin
        hs_r    <= ctr_r;
        hsidx_r <= tgt_r;
      end
      if (cmd.sweep) begin
        swp_cnt_r <= swp_cnt_r + AW'(1);
      end
      if (cmd.index) begin
        mod_cnt_r <= '0;
      end
      if (cmd.mod_step) begin
        mod_cnt_r <= mod_cnt_r + CNT_W'(1);
        if (sts.mod_last) begin
          swp_cnt_r <= '0;
        end
      end
    end
  end

  // Per-item payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ctr_r <= in_packet_counter;
    end
    if (cmd.eval) begin
      over_r   <= (ctr_r >= limit_r);
      borrow_r <= sub_full[CTR_W];
      diff_r   <= sub_full[CTR_W-1:0];
    end
    if (cmd.classify) begin
      gt_r  <= !borrow_r && (diff_r != '0);
      far_r <= (mag_nxt >= CTR_W'(WINDOW));
      mag_r <= mag_nxt;
    end
    if (cmd.index) begin
      tgt_r <= tgt_nxt;
      pos_r <= pos_init[IW-1:0];
      rem_r <= mag_r[IW-1:0];
      mod_r <= '0;
    end
    if (cmd.seg_wr) begin
      pos_r <= pos_wrap[IW-1:0];
      rem_r <= rem_r - IW'(seg_n);
    end
    if (cmd.mod_step) begin
      if (!mod_cnt_r[0]) begin
        quo_r <= quo_nxt;
      end else begin
        mod_r <= mod_nxt;
        if (sts.mod_last) begin
          tgt_r <= mod_nxt;
        end
      end
    end
    if (cmd.report) begin
      out_verdict_r <= cmd.verdict;
    end
  end

  rwc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Status to the controller
  always_comb begin
    sts.over       = over_r;
    sts.gt         = gt_r;
    sts.far        = far_r;
    sts.bit_set    = |(ram_rdata & tgt_mask);
    sts.seg_last   = seg_last;
    sts.mod_last   = (mod_cnt_r == LAST_STEP);
    sts.sweep_last = (swp_cnt_r == LAST_WORD);
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

endmodule

// File: sv/replay_window_check.sv
// Top level of the anti-replay sliding window checker for one session.
//
//   channel  ports                                   transfer
//   input    start, busy, in_operation,              start high, busy low
//            in_packet_counter
//   result   out_valid, out_verdict                  out_valid high, one cycle
//   config   cfg_we, cfg_data                        cfg_we high
//
// Steps from transfer to result strobe (the strobe cycle takes the next item):
// over limit after the compare, too old after classifying, a check in the
// window by one RAM read and write, a small advance by a read and a write per
// bitmap word touched by the cleared run, a jump of a full window or more by an
// eight-step remainder and a write sweep, restart by a wipe sweep. After reset
// busy stays high while a pass clears the bitmap RAM. Results cannot stall.
module replay_window_check import rwc_pkg::*; #(
  parameter int WINDOW = 2048
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_operation,
  input  logic [CTR_W-1:0]     in_packet_counter,
  output logic                 out_valid,
  output logic [VERDICT_W-1:0] out_verdict,
  input  logic                 cfg_we,
  input  logic [CTR_W-1:0]     cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer
  rwc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .sts          (sts),
    .cmd          (cmd),
    .busy         (busy)
  );

  // Datapath and bitmap
  rwc_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_packet_counter (in_packet_counter),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_verdict       (out_verdict)
  );

endmodule
